@@ hw/rtl/slbcs_pkg.sv @@
`timescale 1ns / 1ps

package slbcs_pkg;

  // Field types
  typedef logic [2:0]        net_state_t;
  typedef logic signed [7:0] dbm_t;
  typedef logic [15:0]       ms_t;
  typedef logic [2:0]        flash_cnt_t;
  typedef logic [16:0]       slice_sum_t;

  // Configuration register indexes
  typedef logic [2:0] cfg_index_t;
  localparam cfg_index_t REG_FLASH_MS      = 3'd0;
  localparam cfg_index_t REG_GAP_MS        = 3'd1;
  localparam cfg_index_t REG_GROUP_GAP_MS  = 3'd2;
  localparam cfg_index_t REG_PERIOD_MS     = 3'd3;
  localparam cfg_index_t REG_CHECK_MS      = 3'd4;
  localparam cfg_index_t REG_GOOD_DBM      = 3'd5;
  localparam cfg_index_t REG_FAIR_DBM      = 3'd6;

  // Register defaults after reset
  localparam ms_t  FLASH_MS_DEFAULT      = 16'd40;
  localparam ms_t  GAP_MS_DEFAULT        = 16'd220;
  localparam ms_t  GROUP_GAP_MS_DEFAULT  = 16'd1200;
  localparam ms_t  PERIOD_MS_DEFAULT     = 16'd10000;
  localparam ms_t  CHECK_MS_DEFAULT      = 16'd100;
  localparam dbm_t GOOD_DBM_DEFAULT      = -8'sd65;
  localparam dbm_t FAIR_DBM_DEFAULT      = -8'sd75;

  // Network state codes
  localparam net_state_t NET_CONNECTED   = 3'd0;
  localparam net_state_t NET_ASSOCIATING = 3'd1;
  localparam net_state_t NET_ASSOCIATED  = 3'd2;
  localparam net_state_t NET_AP_MODE     = 3'd3;
  localparam net_state_t NET_NO_CREDS    = 3'd4;

  typedef struct packed {
    ms_t  flash_ms;
    ms_t  gap_ms;
    ms_t  group_gap_ms;
    ms_t  period_ms;
    ms_t  check_ms;
    dbm_t good_dbm;
    dbm_t fair_dbm;
  } cfg_t;

  typedef enum logic [3:0] {
    PH_START     = 4'd0,
    PH_RST_ON    = 4'd1,
    PH_RST_OFF   = 4'd2,
    PH_ON        = 4'd3,
    PH_GAP       = 4'd4,
    PH_GROUP_END = 4'd5,
    PH_GGAP      = 4'd6,
    PH_SLICE_CHK = 4'd7,
    PH_SLICE     = 4'd8
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    ms_t        tick_count;
    flash_cnt_t flashes_left;
    logic       in_second_group;
    slice_sum_t slice_waited;
  } seq_state_t;

  // Phases that count down ticks
  function automatic logic is_timed(phase_t ph);
    return (ph == PH_RST_ON) || (ph == PH_RST_OFF) || (ph == PH_ON) ||
           (ph == PH_GAP) || (ph == PH_GGAP) || (ph == PH_SLICE);
  endfunction

  // Flash count of the first group; unknown codes give two
  function automatic flash_cnt_t state_flashes(net_state_t s);
    flash_cnt_t n;
    unique case (s)
      NET_CONNECTED:   n = 3'd1;
      NET_ASSOCIATING: n = 3'd2;
      NET_ASSOCIATED:  n = 3'd3;
      NET_AP_MODE:     n = 3'd4;
      NET_NO_CREDS:    n = 3'd5;
      default:         n = 3'd2;
    endcase
    return n;
  endfunction

endpackage

@@ hw/rtl/slbcs_ifs.sv @@
`timescale 1ns / 1ps

// Tick channel: one item per millisecond
interface slbcs_in_if;
  import slbcs_pkg::*;
  logic       valid;
  logic       ready;
  net_state_t net_state;
  dbm_t       sig_dbm;
  logic       reset_held;

  modport source(output valid, net_state, sig_dbm, reset_held, input ready);
  modport sink(input valid, net_state, sig_dbm, reset_held, output ready);
endinterface

// LED level channel: one result per tick
interface slbcs_out_if;
  logic valid;
  logic ready;
  logic led_on;
  logic reset_blink_mode;

  modport source(output valid, led_on, reset_blink_mode, input ready);
  modport sink(input valid, led_on, reset_blink_mode, output ready);
endinterface

@@ hw/rtl/slbcs_cfg_regs.sv @@
`timescale 1ns / 1ps

module slbcs_cfg_regs (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  slbcs_pkg::cfg_index_t   cfg_index,
  input  slbcs_pkg::ms_t          cfg_data,
  output slbcs_pkg::cfg_t         cfg
);
  import slbcs_pkg::*;

  // Register file, loaded with defaults on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flash_ms      <= FLASH_MS_DEFAULT;
      cfg.gap_ms        <= GAP_MS_DEFAULT;
      cfg.group_gap_ms  <= GROUP_GAP_MS_DEFAULT;
      cfg.period_ms     <= PERIOD_MS_DEFAULT;
      cfg.check_ms      <= CHECK_MS_DEFAULT;
      cfg.good_dbm      <= GOOD_DBM_DEFAULT;
      cfg.fair_dbm      <= FAIR_DBM_DEFAULT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FLASH_MS:      cfg.flash_ms      <= cfg_data;
        REG_GAP_MS:        cfg.gap_ms        <= cfg_data;
        REG_GROUP_GAP_MS:  cfg.group_gap_ms  <= cfg_data;
        REG_PERIOD_MS:     cfg.period_ms     <= cfg_data;
        REG_CHECK_MS:      cfg.check_ms      <= cfg_data;
        REG_GOOD_DBM:      cfg.good_dbm      <= cfg_data[7:0];
        REG_FAIR_DBM:      cfg.fair_dbm      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/slbcs_seq.sv @@
`timescale 1ns / 1ps

module slbcs_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  slbcs_pkg::cfg_t       cfg,
  input  slbcs_pkg::net_state_t net_state,
  input  slbcs_pkg::dbm_t       sig_dbm,
  input  logic                  reset_held,
  output logic                  led_on,
  output logic                  reset_blink_mode
);
  import slbcs_pkg::*;

  seq_state_t state;
  seq_state_t state_next;

  ms_t        flash_m1;
  ms_t        check_m1;
  ms_t        check_eff;
  flash_cnt_t fl_dec;
  flash_cnt_t sig_flashes;
  slice_sum_t slice_sum;
  slice_sum_t chk_sw;
  logic       go_group_end;
  logic       go_chk;
  logic       go_start;

  // Zero flash or check length counts as one tick
  assign check_eff = (cfg.check_ms == '0) ? 16'd1 : cfg.check_ms;
  assign flash_m1  = (cfg.flash_ms == '0) ? '0 : cfg.flash_ms - 16'd1;
  assign check_m1  = check_eff - 16'd1;
  assign fl_dec    = (state.flashes_left != '0) ? state.flashes_left - 3'd1 : '0;
  assign slice_sum = state.slice_waited + {1'b0, check_eff};

  // Signal group size from the thresholds; none in the second group or at 0 dBm
  always_comb begin
    if (state.in_second_group || sig_dbm == '0) begin
      sig_flashes = '0;
    end else if (sig_dbm >= cfg.good_dbm) begin
      sig_flashes = 3'd3;
    end else if (sig_dbm >= cfg.fair_dbm) begin
      sig_flashes = 3'd2;
    end else begin
      sig_flashes = 3'd1;
    end
  end

  // Resolve all zero-time decisions down to the phase that owns this tick
  always_comb begin
    state_next       = state;
    led_on           = 1'b0;
    reset_blink_mode = 1'b0;
    go_group_end     = 1'b0;
    go_chk           = 1'b0;
    go_start         = 1'b0;
    chk_sw           = state.slice_waited;

    if (is_timed(state.phase) && state.tick_count != '0) begin
      state_next.tick_count = state.tick_count - 16'd1;
      led_on           = (state.phase == PH_RST_ON) || (state.phase == PH_ON);
      reset_blink_mode = (state.phase == PH_RST_ON) || (state.phase == PH_RST_OFF);
    end else begin
      unique case (state.phase)
        PH_RST_ON: begin
          state_next.phase      = PH_RST_OFF;
          state_next.tick_count = check_m1;
          reset_blink_mode      = 1'b1;
        end
        PH_RST_OFF: go_start = 1'b1;
        PH_ON: begin
          state_next.flashes_left = fl_dec;
          if (fl_dec == '0) begin
            go_group_end = 1'b1;
          end else if (cfg.gap_ms != '0) begin
            state_next.phase      = PH_GAP;
            state_next.tick_count = cfg.gap_ms - 16'd1;
          end else begin
            state_next.tick_count = flash_m1;
            led_on                = 1'b1;
          end
        end
        PH_GAP: begin
          state_next.phase      = PH_ON;
          state_next.tick_count = flash_m1;
          led_on                = 1'b1;
        end
        PH_GGAP: begin
          state_next.phase           = PH_ON;
          state_next.in_second_group = 1'b1;
          state_next.tick_count      = flash_m1;
          led_on                     = 1'b1;
        end
        PH_GROUP_END: go_group_end = 1'b1;
        PH_SLICE_CHK: go_chk = 1'b1;
        PH_SLICE: begin
          state_next.slice_waited = slice_sum;
          chk_sw                  = slice_sum;
          go_chk                  = 1'b1;
        end
        default: go_start = 1'b1;
      endcase
    end

    // End of a group: optional signal group, else the idle wait
    if (go_group_end) begin
      if (sig_flashes != '0) begin
        state_next.flashes_left = sig_flashes;
        if (cfg.group_gap_ms != '0) begin
          state_next.phase      = PH_GGAP;
          state_next.tick_count = cfg.group_gap_ms - 16'd1;
        end else begin
          state_next.phase           = PH_ON;
          state_next.in_second_group = 1'b1;
          state_next.tick_count      = flash_m1;
          led_on                     = 1'b1;
        end
      end else begin
        state_next.slice_waited = '0;
        chk_sw                  = '0;
        go_chk                  = 1'b1;
      end
    end

    // Slice boundary: done waiting or reset held restarts the cycle
    if (go_chk) begin
      if (chk_sw >= {1'b0, cfg.period_ms} || reset_held) begin
        go_start = 1'b1;
      end else begin
        state_next.phase      = PH_SLICE;
        state_next.tick_count = check_m1;
      end
    end

    // Cycle start
    if (go_start) begin
      led_on = 1'b1;
      if (reset_held) begin
        state_next.phase      = PH_RST_ON;
        state_next.tick_count = check_m1;
        reset_blink_mode      = 1'b1;
      end else begin
        state_next.phase           = PH_ON;
        state_next.tick_count      = flash_m1;
        state_next.flashes_left    = state_flashes(net_state);
        state_next.in_second_group = 1'b0;
      end
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase           <= PH_START;
      state.tick_count      <= '0;
      state.flashes_left    <= '0;
      state.in_second_group <= 1'b0;
      state.slice_waited    <= '0;
    end else if (step) begin
      state <= state_next;
    end
  end

  // Every tick lands in a counting phase
  a_lands_timed: assert property (@(posedge clk) disable iff (rst)
    step |=> (state.phase == PH_RST_ON || state.phase == PH_RST_OFF ||
              state.phase == PH_ON || state.phase == PH_GAP ||
              state.phase == PH_GGAP || state.phase == PH_SLICE))
    else $error("sequencer stopped outside a counting phase");

  // No group is longer than five flashes
  a_flash_bound: assert property (@(posedge clk) disable iff (rst)
    state.flashes_left <= 3'd5)
    else $error("flash count out of range");

  // A dark tick outside the reset blink belongs to a gap or a slice
  a_dark_phase: assert property (@(posedge clk) disable iff (rst)
    step && !led_on && !reset_blink_mode |=>
      (state.phase == PH_GAP || state.phase == PH_GGAP || state.phase == PH_SLICE))
    else $error("dark tick in a lit phase");

  // Blink mode ticks stay in the reset blink phases
  a_blink_phase: assert property (@(posedge clk) disable iff (rst)
    step && reset_blink_mode |=>
      (state.phase == PH_RST_ON || state.phase == PH_RST_OFF))
    else $error("reset blink flag outside reset blink");

endmodule

@@ hw/rtl/status_led_blink_code_sequencer_core.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Payload                          Transfer when
// item     in   net_state, sig_dbm, reset_held   item.valid && item.ready
// result   out  led_on, reset_blink_mode         result.valid && result.ready
// cfg      in   cfg_index, cfg_data              cfg_we
//
// One tick per cycle sustained while the result is taken; each tick passes
// through the input register and then the result register before it is offered.
// The sequencer state and the result register update together on the cycle a
// tick leaves the input register, so consecutive ticks see each other's state.
// A stalled result holds the input register; the input side stalls only when
// both registers are full. rst is synchronous and restores register defaults.

module status_led_blink_code_sequencer_core (
  input  logic                  clk,
  input  logic                  rst,
  slbcs_in_if.sink              item,
  slbcs_out_if.source           result,
  input  logic                  cfg_we,
  input  slbcs_pkg::cfg_index_t cfg_index,
  input  slbcs_pkg::ms_t        cfg_data
);
  import slbcs_pkg::*;

  cfg_t       cfg;
  logic       in_valid;
  net_state_t in_net_state;
  dbm_t       in_sig_dbm;
  logic       in_reset_held;
  logic       advance;
  logic       led_on_next;
  logic       blink_next;
  logic       out_valid;
  logic       out_led_on;
  logic       out_blink;

  slbcs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Pipeline moves when the result register is free or being drained
  assign advance    = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_net_state  <= item.net_state;
      in_sig_dbm    <= item.sig_dbm;
      in_reset_held <= item.reset_held;
    end
  end

  slbcs_seq u_seq (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .cfg              (cfg),
    .net_state        (in_net_state),
    .sig_dbm          (in_sig_dbm),
    .reset_held       (in_reset_held),
    .led_on           (led_on_next),
    .reset_blink_mode (blink_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_led_on <= led_on_next;
      out_blink  <= blink_next;
    end
  end

  assign result.valid            = out_valid;
  assign result.led_on           = out_led_on;
  assign result.reset_blink_mode = out_blink;

endmodule
